>>> rtl/core/ctcg_pkg.sv
package ctcg_pkg;

	// field widths of the item and result
	localparam int LOGIT_W = 16;
	localparam int NW_W    = 9;
	localparam int CHAR_W  = 8;
	localparam int SCORE_W = 16;

	// running sum of exp(logit - max), Q9.15
	localparam int SUM_W = 24;
	// exp table entry, Q1.15
	localparam int EXP_W = 16;
	// table index carried per beat: a Q8.8 difference shifted right by two
	localparam int K_W = LOGIT_W - 2;

	// queue between front and back, power of two
	localparam int QUEUE_DEPTH = 4;

	localparam logic [SUM_W-1:0] ONE_Q15     = 24'd32768;
	localparam logic [SUM_W-1:0] SUM_LIMIT   = 24'hFF_FFFF;
	localparam logic [EXP_W-1:0] EXP_ONE     = 16'd32768;
	// exp(-1/64) in Q0.32
	localparam logic [31:0]      EXP_STEP_RATIO = 32'd4228380000;

	// what the back does with one beat
	typedef enum logic [1:0] {
		OP_FIRST,
		OP_ADD,
		OP_RISE,
		OP_SKIP
	} ctcg_op_t;

	typedef struct packed {
		ctcg_op_t            op;
		logic [K_W-1:0]      k;
		logic                row_end;
		logic                accepted;
		logic [CHAR_W-1:0]   char_index;
		logic                end_of_sequence;
	} ctcg_item_t;

endpackage

>>> rtl/core/ctcg_if.sv
interface ctcg_in_if;
	logic                                valid;
	logic                                ready;
	logic signed [ctcg_pkg::LOGIT_W-1:0] logit;
	logic                                last_in_row;
	logic                                last_row;

	modport source (output valid, output logit, output last_in_row, output last_row,
		input ready);
	modport sink (input valid, input logit, input last_in_row, input last_row,
		output ready);
endinterface

interface ctcg_out_if;
	logic                          valid;
	logic                          ready;
	logic                          accepted;
	logic [ctcg_pkg::CHAR_W-1:0]   char_index;
	logic [ctcg_pkg::SCORE_W-1:0]  score;
	logic                          end_of_sequence;

	modport source (output valid, output accepted, output char_index, output score,
		output end_of_sequence, input ready);
	modport sink (input valid, input accepted, input char_index, input score,
		input end_of_sequence, output ready);
endinterface

>>> rtl/core/ctcg_fifo.sv
module ctcg_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  ctcg_pkg::ctcg_item_t wr_item,
	output logic                 full,
	input  logic                 rd_en,
	output ctcg_pkg::ctcg_item_t rd_item,
	output logic                 not_empty
);
	import ctcg_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	ctcg_item_t       mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   cnt_q;

	// status
	assign full      = (cnt_q == (PTR_W+1)'(QUEUE_DEPTH));
	assign not_empty = (cnt_q != '0);
	assign rd_item   = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			case ({wr_en, rd_en})
				2'b10:   cnt_q <= cnt_q + (PTR_W+1)'(1);
				2'b01:   cnt_q <= cnt_q - (PTR_W+1)'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// the back never pops an empty queue
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> cnt_q != '0)
		else $error("queue popped while empty");

endmodule

>>> rtl/core/ctcg_front.sv
module ctcg_front #(
	parameter int MAX_CLASSES = 256
) (
	input  logic                         clk,
	input  logic                         arst_n,
	ctcg_in_if.sink                      logits,
	input  logic [ctcg_pkg::NW_W-1:0]    num_words,
	input  logic                         q_full,
	output logic                         push,
	output ctcg_pkg::ctcg_item_t         item
);
	import ctcg_pkg::*;

	localparam int CW   = $clog2(MAX_CLASSES + 1);
	localparam int IW   = $clog2(MAX_CLASSES);
	localparam int CMPW = (IW > NW_W) ? IW : NW_W;

	logic [CW-1:0]             col_q;
	logic signed [LOGIT_W-1:0] max_q;
	logic [IW-1:0]             best_q;
	logic [IW-1:0]             prev_q;

	logic                      accept;
	logic                      rise;
	logic [LOGIT_W:0]          diff_w;
	ctcg_op_t                  op;
	logic signed [LOGIT_W-1:0] nmax;
	logic [IW-1:0]             nbest;
	logic [CW-1:0]             ncol;
	logic                      acc;
	logic [CMPW-1:0]           idx_m1;

	assign logits.ready = !q_full;
	assign accept       = logits.valid && logits.ready;

	// compare with the running maximum; the difference is never negative
	assign rise   = (logits.logit > max_q);
	assign diff_w = rise ? ({logits.logit[LOGIT_W-1], logits.logit} - {max_q[LOGIT_W-1], max_q})
	                     : ({max_q[LOGIT_W-1], max_q} - {logits.logit[LOGIT_W-1], logits.logit});

	// classify the beat and work out the next max and argmax
	always_comb begin
		op    = OP_SKIP;
		nmax  = max_q;
		nbest = best_q;
		ncol  = col_q;
		if (col_q == '0) begin
			op    = OP_FIRST;
			nmax  = logits.logit;
			nbest = '0;
			ncol  = CW'(1);
		end else if (col_q < CW'(MAX_CLASSES)) begin
			ncol = col_q + CW'(1);
			if (rise) begin
				op    = OP_RISE;
				nmax  = logits.logit;
				nbest = col_q[IW-1:0];
			end else begin
				op = OP_ADD;
			end
		end
	end

	// character decision, meaningful on the row's last beat
	assign acc    = (nbest != '0) && (CMPW'(nbest) < CMPW'(num_words)) && (nbest != prev_q);
	assign idx_m1 = CMPW'(nbest) - CMPW'(1);

	assign item.op              = op;
	assign item.k               = diff_w[LOGIT_W-1:2];
	assign item.row_end         = logits.last_in_row;
	assign item.accepted        = acc;
	assign item.char_index      = acc ? idx_m1[CHAR_W-1:0] : '0;
	assign item.end_of_sequence = logits.last_row;

	// ignored columns are dropped unless they close the row
	assign push = accept && ((op != OP_SKIP) || logits.last_in_row);

	// row state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			max_q  <= '0;
			best_q <= '0;
			prev_q <= '0;
		end else if (accept) begin
			if (logits.last_in_row) begin
				col_q  <= '0;
				max_q  <= '0;
				best_q <= '0;
				prev_q <= logits.last_row ? '0 : nbest;
			end else begin
				col_q  <= ncol;
				max_q  <= nmax;
				best_q <= nbest;
			end
		end
	end

	// a row end always restarts the column count
	a_row_restart: assert property (@(posedge clk) disable iff (!arst_n)
		accept && logits.last_in_row |=> col_q == '0)
		else $error("column count not cleared after row end");

endmodule

>>> rtl/core/ctcg_div.sv
module ctcg_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [ctcg_pkg::SUM_W-1:0]    divisor,
	output logic                          busy,
	output logic                          done,
	output logic [ctcg_pkg::SCORE_W-1:0]  score
);
	import ctcg_pkg::*;

	// quotient has one bit above the score so that 1.0 can saturate
	localparam int QW     = SCORE_W + 1;
	localparam int REM_W  = 32;
	localparam int DIV_W  = SUM_W + SCORE_W;
	localparam int STEP_W = $clog2(QW + 1);

	logic [REM_W-1:0]  rem_q;
	logic [DIV_W-1:0]  div_q;
	logic [QW-1:0]     quot_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;

	logic              ge;
	logic [DIV_W-1:0]  diff;

	// one restoring step: (2^31 + sum/2) / sum, one quotient bit a cycle;
	// a zero divisor yields all ones and saturates like the model
	assign ge   = (DIV_W'(rem_q) >= div_q);
	assign diff = DIV_W'(rem_q) - div_q;

	assign busy  = busy_q;
	assign done  = done_q;
	assign score = quot_q[QW-1] ? '1 : quot_q[SCORE_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			div_q  <= '0;
			quot_q <= '0;
			step_q <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				rem_q  <= 32'h8000_0000 + REM_W'(divisor[SUM_W-1:1]);
				div_q  <= {divisor, {SCORE_W{1'b0}}};
				quot_q <= '0;
				step_q <= STEP_W'(QW);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (ge) begin
					rem_q <= diff[REM_W-1:0];
				end
				quot_q <= {quot_q[QW-2:0], ge};
				div_q  <= div_q >> 1;
				step_q <= step_q - STEP_W'(1);
				if (step_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// a new division only starts once the last one is finished
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("divider restarted while busy");

endmodule

>>> rtl/core/ctcg_back.sv
module ctcg_back #(
	parameter int EXP_TABLE_DEPTH = 1024
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_valid,
	input  ctcg_pkg::ctcg_item_t q_item,
	output logic                 q_pop,
	ctcg_out_if.source           results
);
	import ctcg_pkg::*;

	localparam int AW = $clog2(EXP_TABLE_DEPTH);

	typedef enum logic [3:0] {
		S_FILL_INIT,
		S_FILL_WR,
		S_FILL_MUL,
		S_IDLE,
		S_APPLY,
		S_RISE,
		S_START,
		S_WAIT,
		S_OUT
	} back_state_t;

	back_state_t        state_q;
	ctcg_item_t         item_q;
	logic [SUM_W-1:0]   sum_q;
	logic [SCORE_W-1:0] score_q;
	logic [31:0]        v_q;
	logic [AW-1:0]      fill_addr_q;
	logic [63:0]        prod_q;

	logic [EXP_W-1:0]   rom_mem [EXP_TABLE_DEPTH];
	logic [EXP_W-1:0]   rom_rdata_q;
	logic               rom_we;
	logic [AW-1:0]      rom_waddr;
	logic [EXP_W-1:0]   rom_wdata;

	logic               filling;
	logic [32:0]        fill_round;
	logic [63:0]        v_round;
	logic               far;
	logic [EXP_W-1:0]   e_val;
	logic [31:0]        mul_a;
	logic [31:0]        mul_b;
	logic [63:0]        mul_p;
	logic [SUM_W:0]     add_sum;
	logic [SUM_W+16:0]  rise_round;
	logic [SUM_W+2:0]   rise_sum;

	logic               div_start;
	logic               div_busy;
	logic               div_done;
	logic [SCORE_W-1:0] div_score;

	ctcg_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.divisor (sum_q),
		.busy    (div_busy),
		.done    (div_done),
		.score   (div_score)
	);

	// table fill arithmetic: entry = (v + 2^16) >> 17, v' = (v * R + 2^31) >> 32
	assign filling    = (state_q == S_FILL_INIT) || (state_q == S_FILL_WR)
	                 || (state_q == S_FILL_MUL);
	assign fill_round = {1'b0, v_q} + 33'h1_0000;
	assign v_round    = prod_q + 64'h8000_0000;

	// table write port
	always_comb begin
		rom_we    = 1'b0;
		rom_waddr = fill_addr_q;
		rom_wdata = fill_round[32:17];
		case (state_q)
			S_FILL_INIT: begin
				rom_we    = 1'b1;
				rom_waddr = '0;
				rom_wdata = EXP_ONE;
			end
			S_FILL_WR: begin
				rom_we = 1'b1;
			end
			default: begin
				rom_we = 1'b0;
			end
		endcase
	end

	// exp table, read every cycle at the head beat's index
	always_ff @(posedge clk) begin
		if (rom_we) begin
			rom_mem[rom_waddr] <= rom_wdata;
		end
		rom_rdata_q <= rom_mem[AW'(q_item.k)];
	end

	// differences past the table end weigh nothing
	assign far   = (32'(item_q.k) >= 32'(EXP_TABLE_DEPTH));
	assign e_val = far ? '0 : rom_rdata_q;

	// one shared multiplier: table fill or rescale of the sum
	assign mul_a = filling ? v_q : 32'(sum_q);
	assign mul_b = filling ? EXP_STEP_RATIO : 32'(e_val);
	assign mul_p = 64'(mul_a) * 64'(mul_b);

	// sum updates
	assign add_sum    = {1'b0, sum_q} + (SUM_W+1)'(e_val);
	assign rise_round = prod_q[SUM_W+16:0] + (SUM_W+17)'(15'h4000);
	assign rise_sum   = (SUM_W+3)'(rise_round[SUM_W+16:15]) + (SUM_W+3)'(ONE_Q15);

	assign q_pop     = (state_q == S_IDLE) && q_valid;
	assign div_start = (state_q == S_START);

	assign results.valid           = (state_q == S_OUT);
	assign results.accepted        = item_q.accepted;
	assign results.char_index      = item_q.char_index;
	assign results.score           = score_q;
	assign results.end_of_sequence = item_q.end_of_sequence;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_FILL_INIT;
			item_q      <= '0;
			sum_q       <= '0;
			score_q     <= '0;
			v_q         <= '0;
			fill_addr_q <= '0;
			prod_q      <= '0;
		end else begin
			case (state_q)
				S_FILL_INIT: begin
					v_q         <= EXP_STEP_RATIO;
					fill_addr_q <= AW'(1);
					state_q     <= S_FILL_WR;
				end
				S_FILL_WR: begin
					prod_q <= mul_p;
					if (fill_addr_q == AW'(EXP_TABLE_DEPTH - 1)) begin
						state_q <= S_IDLE;
					end else begin
						state_q <= S_FILL_MUL;
					end
				end
				S_FILL_MUL: begin
					v_q         <= v_round[63:32];
					fill_addr_q <= fill_addr_q + AW'(1);
					state_q     <= S_FILL_WR;
				end
				S_IDLE: begin
					if (q_valid) begin
						item_q <= q_item;
						case (q_item.op)
							OP_FIRST: begin
								sum_q   <= ONE_Q15;
								state_q <= q_item.row_end ? S_START : S_IDLE;
							end
							OP_ADD, OP_RISE: begin
								state_q <= S_APPLY;
							end
							default: begin
								state_q <= q_item.row_end ? S_START : S_IDLE;
							end
						endcase
					end
				end
				S_APPLY: begin
					if (item_q.op == OP_RISE) begin
						prod_q  <= mul_p;
						state_q <= S_RISE;
					end else begin
						sum_q   <= add_sum[SUM_W] ? SUM_LIMIT : add_sum[SUM_W-1:0];
						state_q <= item_q.row_end ? S_START : S_IDLE;
					end
				end
				S_RISE: begin
					sum_q   <= (rise_sum > (SUM_W+3)'(SUM_LIMIT)) ? SUM_LIMIT
					                                              : rise_sum[SUM_W-1:0];
					state_q <= item_q.row_end ? S_START : S_IDLE;
				end
				S_START: begin
					state_q <= S_WAIT;
				end
				S_WAIT: begin
					if (div_done) begin
						score_q <= div_score;
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (results.ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// the divider answers only while the sequencer waits for it
	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == S_WAIT)
		else $error("score ready outside wait state");

	// a started division keeps the divider busy
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_START |=> div_busy)
		else $error("divider did not start");

endmodule

>>> rtl/core/ctc_greedy_decoder_with_score_core.sv
// CTC greedy (best path) decoder with softmax peak score.
// logits: one signed Q8.8 class logit per beat, class 0 first; last_in_row
//   closes a time step and last_row marks the step that ends the sequence.
// results: one beat per time step with accepted, char_index (class minus
//   one), score (1/sum of exp, unsigned Q0.16, saturated) and end_of_sequence.
// cfg_we / cfg_wdata write num_words, the alphabet size (256 after reset).
// The front tracks max and argmax at one logit per cycle while the
// four-entry queue it feeds has room; the back reads the exp table and
// updates the sum, one beat at a time. A row's first logit takes only
// S_IDLE; a later logit also passes S_APPLY and, when the maximum rises,
// S_RISE, set by the registered table read and the shared multiplier.
// A row end adds the bit-serial score division (S_START, S_WAIT) and the
// handoff in S_OUT.
// Reset: the back fills the exp table with a sweep of S_FILL_WR and
// S_FILL_MUL steps; logits are taken into the queue meanwhile and
// wait there. When results are stalled the back holds its result and the
// queue fills, after which logits.ready drops.
module ctc_greedy_decoder_with_score_core #(
	parameter int MAX_CLASSES     = 256,
	parameter int EXP_TABLE_DEPTH = 1024
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [ctcg_pkg::NW_W-1:0] cfg_wdata,
	ctcg_in_if.sink                   logits,
	ctcg_out_if.source                results
);
	import ctcg_pkg::*;

	logic [NW_W-1:0] num_words_q;
	logic            q_full;
	logic            q_push;
	ctcg_item_t      q_wr_item;
	logic            q_pop;
	ctcg_item_t      q_rd_item;
	logic            q_valid;

	// alphabet size register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_words_q <= 9'd256;
		end else if (cfg_we) begin
			num_words_q <= cfg_wdata;
		end
	end

	ctcg_front #(
		.MAX_CLASSES (MAX_CLASSES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.logits    (logits),
		.num_words (num_words_q),
		.q_full    (q_full),
		.push      (q_push),
		.item      (q_wr_item)
	);

	ctcg_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (q_push),
		.wr_item   (q_wr_item),
		.full      (q_full),
		.rd_en     (q_pop),
		.rd_item   (q_rd_item),
		.not_empty (q_valid)
	);

	ctcg_back #(
		.EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_item  (q_rd_item),
		.q_pop   (q_pop),
		.results (results)
	);

endmodule
